@@ sv/tsfh_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsfh_pkg
// Shared types and constants for the three-axis step follower with homing.
// ---------------------------------------------------------------------------
package tsfh_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned PosW     = 32;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic signed [PosW-1:0] PosReset  = 32'sd40960000; // 10000 mm in Q19.12
  localparam logic        [CfgW-1:0] StepReset = 31'd41;
  localparam logic        [CfgW-1:0] TolReset  = 31'd0;

  typedef enum logic [1:0] {
    OP_SET_TARGET = 2'd0,
    OP_MOVE       = 2'd1,
    OP_HOME       = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_X = 3'd0,
    CFG_STEP_Y = 3'd1,
    CFG_STEP_Z = 3'd2,
    CFG_TOL_X  = 3'd3,
    CFG_TOL_Y  = 3'd4,
    CFG_TOL_Z  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic signed [PosW-1:0] new_target_x;
    logic signed [PosW-1:0] new_target_y;
    logic signed [PosW-1:0] new_target_z;
    logic                   lim_x_min;
    logic                   lim_y_min;
    logic                   lim_z_min;
  } in_req_t;

  typedef struct packed {
    logic       step_x;
    logic       dir_x;
    logic       step_y;
    logic       dir_y;
    logic       step_z;
    logic       dir_z;
    logic [2:0] moving_flags;
    logic       home_done;
  } out_res_t;

  // per-axis control into the axis unit
  typedef struct packed {
    logic move;
    logic home;
    logic reached;
    logic lim;
    logic invert;
  } axis_ctrl_t;

  // per-axis decision out of the axis unit
  typedef struct packed {
    logic step;
    logic dir;
    logic reach;
  } axis_stat_t;

endpackage : tsfh_pkg
`default_nettype wire

@@ sv/tsfh_axis.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tsfh_axis
// One axis: deadband compare, saturating step add or subtract, homing step.
// ---------------------------------------------------------------------------
module tsfh_axis (
  input  wire  tsfh_pkg::axis_ctrl_t              ctrl_i,
  input  logic signed [tsfh_pkg::PosW-1:0]        pos_i,
  input  logic signed [tsfh_pkg::PosW-1:0]        goal_i,
  input  logic        [tsfh_pkg::CfgW-1:0]        step_size_i,
  input  logic        [tsfh_pkg::CfgW-1:0]        tolerance_i,
  output tsfh_pkg::axis_stat_t                    stat_o,
  output logic signed [tsfh_pkg::PosW-1:0]        pos_o
);
  import tsfh_pkg::*;

  localparam int unsigned WideW = PosW + 2;
  localparam logic signed [WideW-1:0] PosMax = WideW'(34'sh0_7FFF_FFFF);
  localparam logic signed [WideW-1:0] PosMin = -WideW'(34'sh0_8000_0000);

  logic signed [WideW-1:0] pos_w;
  logic signed [WideW-1:0] goal_w;
  logic signed [WideW-1:0] step_w;
  logic signed [WideW-1:0] tol_w;
  logic signed [WideW-1:0] lo_w;
  logic signed [WideW-1:0] hi_w;
  logic signed [WideW-1:0] sum_up;
  logic signed [WideW-1:0] sum_dn;
  logic signed [PosW-1:0]  sat_up;
  logic signed [PosW-1:0]  sat_dn;
  logic                    below;
  logic                    above;
  logic                    step;
  logic                    up;
  logic                    reach;

  // widen so bounds and sums never wrap
  assign pos_w  = WideW'(pos_i);
  assign goal_w = WideW'(goal_i);
  assign step_w = $signed({{(WideW-CfgW){1'b0}}, step_size_i});
  assign tol_w  = $signed({{(WideW-CfgW){1'b0}}, tolerance_i});
  assign lo_w   = goal_w - tol_w;
  assign hi_w   = goal_w + tol_w;
  assign below  = pos_w < lo_w;
  assign above  = pos_w > hi_w;

  // saturating step in either direction
  assign sum_up = pos_w + step_w;
  assign sum_dn = pos_w - step_w;
  assign sat_up = (sum_up > PosMax) ? PosMax[PosW-1:0] : sum_up[PosW-1:0];
  assign sat_dn = (sum_dn < PosMin) ? PosMin[PosW-1:0] : sum_dn[PosW-1:0];

  // step decision
  always_comb begin
    step  = 1'b0;
    up    = 1'b0;
    pos_o = pos_i;
    reach = 1'b0;
    if (ctrl_i.move) begin
      if (below) begin
        step  = 1'b1;
        up    = 1'b1;
        pos_o = sat_up;
      end else if (above) begin
        step  = 1'b1;
        pos_o = sat_dn;
      end
    end else if (ctrl_i.home && !ctrl_i.reached) begin
      if (ctrl_i.lim) begin
        reach = 1'b1;
      end else begin
        step  = 1'b1;
        pos_o = sat_dn;
      end
    end
  end

  // direction pin is low on an idle axis
  assign stat_o.step  = step;
  assign stat_o.dir   = step & (up ^ ctrl_i.invert);
  assign stat_o.reach = reach;

endmodule : tsfh_axis
`default_nettype wire

@@ sv/three_axis_step_follower_homing.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// three_axis_step_follower_homing
// Three-axis bang-bang stepper follower with homing on the minimum switches.
// ---------------------------------------------------------------------------
// Every request (set target, move tick or homing tick) is handled in the
// cycle it is accepted: the deadband compare and saturating step of each
// axis run on the held positions, and the result lands in an output
// register. A skid register behind it lets one more request in while a
// result waits, so one request per cycle is sustained whenever results are
// taken. Step sizes and tolerances are written through the plain write port
// at indexes 0..5 (x, y, z step size, then x, y, z tolerance); other
// indexes are ignored. Positions reset to 10000 mm, goals to zero.
module three_axis_step_follower_homing (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [tsfh_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [tsfh_pkg::CfgW-1:0]         cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  tsfh_pkg::in_req_t           in_req_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output tsfh_pkg::out_res_t                out_res_o
);
  import tsfh_pkg::*;

  logic signed [PosW-1:0] pos_q  [NumAxes];
  logic signed [PosW-1:0] pos_d  [NumAxes];
  logic signed [PosW-1:0] pos_nx [NumAxes];
  logic signed [PosW-1:0] goal_q [NumAxes];
  logic        [CfgW-1:0] step_q [NumAxes];
  logic        [CfgW-1:0] tol_q  [NumAxes];
  logic [NumAxes-1:0]     reached_q, reached_d;
  logic [NumAxes-1:0]     moving_q, moving_d;
  logic [NumAxes-1:0]     lim;
  logic [NumAxes-1:0]     step;
  logic [NumAxes-1:0]     dir;
  logic [NumAxes-1:0]     reach;
  logic [NumAxes-1:0]     reached_all;
  logic                   op_set, op_move, op_home;
  logic                   done;
  logic                   in_fire;
  logic                   out_free;
  out_res_t               res;
  out_res_t               out_q, skid_q;
  logic                   out_valid_q, skid_valid_q;
  axis_ctrl_t             ctrl  [NumAxes];
  axis_stat_t             stat  [NumAxes];

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // operation decode
  always_comb begin
    op_set  = 1'b0;
    op_move = 1'b0;
    op_home = 1'b0;
    case (op_e'(in_req_i.operation))
      OP_SET_TARGET: op_set  = 1'b1;
      OP_MOVE:       op_move = 1'b1;
      OP_HOME:       op_home = 1'b1;
      default:       ;
    endcase
  end

  assign lim = {in_req_i.lim_z_min, in_req_i.lim_y_min, in_req_i.lim_x_min};

  // per-axis units, y has inverted direction polarity
  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    assign ctrl[a] = '{move:    op_move,
                       home:    op_home,
                       reached: reached_q[a],
                       lim:     lim[a],
                       invert:  (a == 1)};
    tsfh_axis u_axis (
      .ctrl_i      (ctrl[a]),
      .pos_i       (pos_q[a]),
      .goal_i      (goal_q[a]),
      .step_size_i (step_q[a]),
      .tolerance_i (tol_q[a]),
      .stat_o      (stat[a]),
      .pos_o       (pos_nx[a])
    );
    assign step[a]  = stat[a].step;
    assign dir[a]   = stat[a].dir;
    assign reach[a] = stat[a].reach;
  end

  // homing completion and state next values
  assign reached_all = reached_q | reach;
  assign done        = op_home && (reached_all == {NumAxes{1'b1}});

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      pos_d[a] = done ? '0 : pos_nx[a];
    end
    reached_d = reached_q;
    if (op_home) begin
      reached_d = done ? '0 : reached_all;
    end
    moving_d = op_move ? step : moving_q;
  end

  // result of the request in flight
  always_comb begin
    res.step_x       = step[0];
    res.dir_x        = dir[0];
    res.step_y       = step[1];
    res.dir_y        = dir[1];
    res.step_z       = step[2];
    res.dir_z        = dir[2];
    res.moving_flags = moving_d;
    res.home_done    = done;
  end

  // axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        pos_q[a]  <= PosReset;
        goal_q[a] <= '0;
      end
      reached_q <= '0;
      moving_q  <= '0;
    end else if (in_fire) begin
      if (op_set) begin
        goal_q[0] <= in_req_i.new_target_x;
        goal_q[1] <= in_req_i.new_target_y;
        goal_q[2] <= in_req_i.new_target_z;
      end
      for (int a = 0; a < NumAxes; a++) begin
        pos_q[a] <= pos_d[a];
      end
      reached_q <= reached_d;
      moving_q  <= moving_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        step_q[a] <= StepReset;
        tol_q[a]  <= TolReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_X: step_q[0] <= cfg_data_i;
        CFG_STEP_Y: step_q[1] <= cfg_data_i;
        CFG_STEP_Z: step_q[2] <= cfg_data_i;
        CFG_TOL_X:  tol_q[0]  <= cfg_data_i;
        CFG_TOL_Y:  tol_q[1]  <= cfg_data_i;
        CFG_TOL_Z:  tol_q[2]  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // checks
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost or changed");

  a_reached_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    reached_q != {NumAxes{1'b1}})
    else $error("all axes reached without homing completing");

  a_done_no_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.home_done) |-> !(out_q.step_x || out_q.step_y || out_q.step_z))
    else $error("homing reported done while an axis steps");

endmodule : three_axis_step_follower_homing
`default_nettype wire
